>>> rtl/brw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brw_pkg
// Shared constants and types for the ray walker: grid size, widths of the
// coordinate, error and step fields, stream widths and unit interfaces.
// ----------------------------------------------------------------------------
package brw_pkg;

    // grid geometry
    localparam int GRID_BITS = 6;
    localparam int COORD_W   = GRID_BITS;
    localparam int MAP_AW    = 2 * GRID_BITS;
    localparam int MAP_DEPTH = 1 << MAP_AW;

    // walk arithmetic: error term holds +/- 2 * major, step count holds the side
    localparam int ERR_W  = COORD_W + 3;
    localparam int STEP_W = COORD_W + 1;

    // stream widths, padded to whole bytes
    localparam int S_DATA_W = ((4 * COORD_W + 1 + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * COORD_W + 7) / 8) * 8;

    // item kinds on the input stream
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    typedef logic [COORD_W-1:0]       coord_t;
    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic [MAP_AW-1:0]        map_addr_t;

    // operands of the shared step unit
    typedef struct packed {
        coord_t x;
        coord_t y;
        err_t   err;
        logic   steep;
        logic   neg_x;
        logic   neg_y;
        err_t   inc_a;
        err_t   inc_b;
    } step_in_t;

    // result of one step
    typedef struct packed {
        coord_t x;
        coord_t y;
        err_t   err;
    } step_out_t;

    // map write request
    typedef struct packed {
        logic      en;
        map_addr_t addr;
        logic      data;
    } map_wr_t;

endpackage

>>> rtl/brw_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brw_step_unit
// One Bresenham step: moves along the major axis, along the minor axis when
// the error term is not negative, and updates the error term with one add.
// ----------------------------------------------------------------------------
module brw_step_unit (
    input  brw_pkg::step_in_t  step_in,
    output brw_pkg::step_out_t step_out
);
    import brw_pkg::*;

    logic   adv;
    logic   move_x;
    logic   move_y;
    coord_t x_moved;
    coord_t y_moved;

    // minor axis advances when the error term is zero or positive
    assign adv    = ~step_in.err[ERR_W-1];
    assign move_x = ~step_in.steep | adv;
    assign move_y = step_in.steep | adv;

    // unit moves with wrap on the grid
    assign x_moved = step_in.neg_x ? step_in.x - COORD_W'(1) : step_in.x + COORD_W'(1);
    assign y_moved = step_in.neg_y ? step_in.y - COORD_W'(1) : step_in.y + COORD_W'(1);

    assign step_out.x   = move_x ? x_moved : step_in.x;
    assign step_out.y   = move_y ? y_moved : step_in.y;
    assign step_out.err = step_in.err + (adv ? step_in.inc_b : step_in.inc_a);

endmodule

>>> rtl/brw_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brw_map
// Blocker occupancy map, one bit per tile, with registered read data.
// After reset a clearing pass writes zero to every tile, one per cycle.
// ----------------------------------------------------------------------------
module brw_map (
    input  logic                aclk,
    input  logic                aresetn,
    input  brw_pkg::map_wr_t    wr,
    input  logic                rd_en,
    input  brw_pkg::map_addr_t  rd_addr,
    output logic                rd_data,
    output logic                busy
);
    import brw_pkg::*;

    logic      mem [MAP_DEPTH];
    map_addr_t clr_addr_reg;
    map_addr_t clr_addr_next;
    logic      clr_busy_reg;
    logic      clr_busy_next;
    logic      rd_data_reg;
    logic      we;
    map_addr_t waddr;
    logic      wdata;

    // clearing sweep control
    always_comb begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + MAP_AW'(1);
            if (clr_addr_reg == {MAP_AW{1'b1}}) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // single write port shared by the sweep and map writes
    assign we    = clr_busy_reg | wr.en;
    assign waddr = clr_busy_reg ? clr_addr_reg : wr.addr;
    assign wdata = clr_busy_reg ? 1'b0 : wr.data;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

>>> rtl/bresenham_ray_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_ray_walker
// Walks a Bresenham line over a local blocker map and streams the visited
// tiles; the walk ends at the end tile or at the first blocking tile past
// the start. Write items set or clear one map bit.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (low bit up)                               tuser         tlast
//  s_axis    in   start_x, start_y, end_x, end_y, block_bit        op            -
//  m_axis    out  tile_x, tile_y                                   hit_blocker   last_tile
//
//  A write item is taken in S_IDLE. A cast is captured in S_IDLE, puts out
//  the start tile from S_START, then for each further tile steps and issues
//  the map read in S_STEP and puts the tile out in S_CHECK, so the input is
//  held until the walk ends; the shared step unit and the single map read
//  port set that order. After reset the map clears all 4096 tiles before
//  the first transfer. A stalled m_axis holds the walk in place; one result
//  waits in the output register while the next input transfer is taken.
// ----------------------------------------------------------------------------
module bresenham_ray_walker (
    input  logic                          aclk,
    input  logic                          aresetn,
    // start_x, start_y, end_x, end_y, block_bit, zero pad
    input  logic [brw_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tile_x, tile_y, zero pad
    output logic [brw_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // hit_blocker
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready
);
    import brw_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_STEP  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0]        state_reg, state_next;
    coord_t            sx_reg, sx_next;
    coord_t            sy_reg, sy_next;
    coord_t            ex_reg, ex_next;
    coord_t            ey_reg, ey_next;
    coord_t            x_reg, x_next;
    coord_t            y_reg, y_next;
    err_t              err_reg, err_next;
    err_t              inc_a_reg, inc_a_next;
    err_t              inc_b_reg, inc_b_next;
    logic              steep_reg, steep_next;
    logic              neg_x_reg, neg_x_next;
    logic              neg_y_reg, neg_y_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    coord_t            out_x_reg, out_x_next;
    coord_t            out_y_reg, out_y_next;
    logic              out_hit_reg, out_hit_next;
    logic              out_last_reg, out_last_next;
    logic              out_valid_reg, out_valid_next;

    logic              in_xfer;
    logic              out_free;
    logic              in_op;
    coord_t            in_sx, in_sy, in_ex, in_ey;
    logic              in_bit;
    coord_t            dx, dy, major, minor;
    logic              setup_steep;
    err_t              setup_err;
    err_t              setup_inc_a;
    err_t              setup_inc_b;
    step_in_t          step_in;
    step_out_t         step_out;
    map_wr_t           map_wr;
    logic              map_rd_en;
    map_addr_t         map_rd_addr;
    logic              map_rd_data;
    logic              map_busy;
    logic              last_now;

    // input field unpacking
    assign in_op = s_axis_tuser;
    assign in_sx = s_axis_tdata[COORD_W-1:0];
    assign in_sy = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_ex = s_axis_tdata[3*COORD_W-1:2*COORD_W];
    assign in_ey = s_axis_tdata[4*COORD_W-1:3*COORD_W];
    assign in_bit = s_axis_tdata[4*COORD_W];

    assign s_axis_tready = (state_reg == S_IDLE) & ~map_busy;
    assign in_xfer       = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~out_valid_reg | m_axis_tready;

    // line setup from the captured endpoints
    assign dx          = (ex_reg >= sx_reg) ? ex_reg - sx_reg : sx_reg - ex_reg;
    assign dy          = (ey_reg >= sy_reg) ? ey_reg - sy_reg : sy_reg - ey_reg;
    assign setup_steep = dy > dx;
    assign major       = setup_steep ? dy : dx;
    assign minor       = setup_steep ? dx : dy;
    assign setup_inc_a = ERR_W'(minor) <<< 1;
    assign setup_inc_b = (ERR_W'(minor) <<< 1) - (ERR_W'(major) <<< 1);
    assign setup_err   = (ERR_W'(minor) <<< 1) - ERR_W'(major);

    // shared step unit
    assign step_in.x     = x_reg;
    assign step_in.y     = y_reg;
    assign step_in.err   = err_reg;
    assign step_in.steep = steep_reg;
    assign step_in.neg_x = neg_x_reg;
    assign step_in.neg_y = neg_y_reg;
    assign step_in.inc_a = inc_a_reg;
    assign step_in.inc_b = inc_b_reg;

    brw_step_unit u_step (
        .step_in  (step_in),
        .step_out (step_out)
    );

    // map access: writes from input transfers, reads of each new tile
    assign map_wr.en    = in_xfer & (in_op == OP_WRITE);
    assign map_wr.addr  = {in_sy, in_sx};
    assign map_wr.data  = in_bit;
    assign map_rd_en    = (state_reg == S_STEP);
    assign map_rd_addr  = {step_out.y, step_out.x};

    brw_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (map_wr),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .busy    (map_busy)
    );

    assign last_now = map_rd_data | (steps_reg == '0);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        err_next       = err_reg;
        inc_a_next     = inc_a_reg;
        inc_b_next     = inc_b_reg;
        steep_next     = steep_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        steps_next     = steps_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_hit_next   = out_hit_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer && (in_op == OP_CAST)) begin
                    sx_next    = in_sx;
                    sy_next    = in_sy;
                    ex_next    = in_ex;
                    ey_next    = in_ey;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (out_free) begin
                    x_next         = sx_reg;
                    y_next         = sy_reg;
                    err_next       = setup_err;
                    inc_a_next     = setup_inc_a;
                    inc_b_next     = setup_inc_b;
                    steep_next     = setup_steep;
                    neg_x_next     = ex_reg < sx_reg;
                    neg_y_next     = ey_reg < sy_reg;
                    steps_next     = STEP_W'(major);
                    out_x_next     = sx_reg;
                    out_y_next     = sy_reg;
                    out_hit_next   = 1'b0;
                    out_last_next  = (major == '0);
                    out_valid_next = 1'b1;
                    state_next     = (major == '0) ? S_IDLE : S_STEP;
                end
            end
            S_STEP: begin
                x_next     = step_out.x;
                y_next     = step_out.y;
                err_next   = step_out.err;
                steps_next = steps_reg - STEP_W'(1);
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (out_free) begin
                    out_x_next     = x_reg;
                    out_y_next     = y_reg;
                    out_hit_next   = map_rd_data;
                    out_last_next  = last_now;
                    out_valid_next = 1'b1;
                    state_next     = last_now ? S_IDLE : S_STEP;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // walk and result payload
    always_ff @(posedge aclk) begin
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        err_reg      <= err_next;
        inc_a_reg    <= inc_a_next;
        inc_b_reg    <= inc_b_next;
        steep_reg    <= steep_next;
        neg_x_reg    <= neg_x_next;
        neg_y_reg    <= neg_y_next;
        steps_reg    <= steps_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_hit_reg  <= out_hit_next;
        out_last_reg <= out_last_next;
    end

    // result stream
    assign m_axis_tdata  = M_DATA_W'({out_y_reg, out_x_reg});
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tvalid = out_valid_reg;

endmodule

>>> bench/bresenham_ray_walker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_ray_walker_tb
// Self-checking bench for the ray walker. Map writes and ray casts go in on
// the input stream, and a tile-level predictor keeps its own copy of the
// blocker map and works out every tile that each cast should produce. Each
// result transfer is checked against the oldest predicted tile. Directed
// rays cover every line shape and blocker case, then random traffic mixes
// dense blocker writes with casts. Both sides idle, and one long output
// hold-off fills the block.
// ----------------------------------------------------------------------------
module bresenham_ray_walker_tb;
    import brw_pkg::*;

    localparam int GRID_SIDE = 1 << GRID_BITS;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 300;

    // one input item
    typedef struct packed {
        logic   op;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        logic   blk;
    } ray_cmd_t;

    // one visited tile
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   hit;
        logic   last;
    } tile_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;

    // predictor state and bookkeeping
    bit    blocked_tiles [0:MAP_DEPTH-1];
    tile_t pending_tiles [$];
    int    burst_left = 0;
    int    n_errors = 0;
    int    n_casts = 0;
    int    n_writes = 0;
    int    n_tiles = 0;
    int    n_hits = 0;
    bit    hold_req = 1'b0;

    always #5 aclk = ~aclk;

    bresenham_ray_walker u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // walk one ray over the predicted map and queue its tiles
    function automatic void trace_ray(input coord_t sx, input coord_t sy,
                                      input coord_t ex, input coord_t ey);
        int    dx;
        int    dy;
        int    stx;
        int    sty;
        int    err;
        int    left;
        int    px;
        int    py;
        int    idx;
        bit    steep;
        bit    hit;
        tile_t t;
        tile_t path [$];
        dx  = (ex >= sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
        dy  = (ey >= sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
        stx = (ex >= sx) ? 1 : -1;
        sty = (ey >= sy) ? 1 : -1;
        steep = dy > dx;
        px = sx;
        py = sy;
        // start tile is never tested against the map
        t.x = sx;
        t.y = sy;
        t.hit = 1'b0;
        t.last = 1'b0;
        path = {path, t};
        err  = steep ? 2 * dx - dy : 2 * dy - dx;
        left = steep ? dy : dx;
        while (left > 0) begin
            if (steep) begin
                py += sty;
                if (err >= 0) begin
                    px += stx;
                    err += 2 * dx - 2 * dy;
                end else begin
                    err += 2 * dx;
                end
            end else begin
                px += stx;
                if (err >= 0) begin
                    py += sty;
                    err += 2 * dy - 2 * dx;
                end else begin
                    err += 2 * dy;
                end
            end
            left--;
            idx = ((py & (GRID_SIDE - 1)) << GRID_BITS) | (px & (GRID_SIDE - 1));
            hit = blocked_tiles[idx];
            t.x = coord_t'(px);
            t.y = coord_t'(py);
            t.hit = hit;
            path = {path, t};
            if (hit)
                left = 0;
        end
        path[path.size() - 1].last = 1'b1;
        foreach (path[i])
            pending_tiles = {pending_tiles, path[i]};
    endfunction

    // update the predictor for one accepted item
    function automatic void apply_cmd(input ray_cmd_t cmd);
        if (cmd.op == OP_WRITE) begin
            blocked_tiles[{cmd.sy, cmd.sx}] = cmd.blk;
            n_writes++;
        end else begin
            trace_ray(cmd.sx, cmd.sy, cmd.ex, cmd.ey);
            n_casts++;
        end
    endfunction

    // offer one item in bursts with random gaps, wait for its transfer
    task automatic send_cmd(input ray_cmd_t cmd);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_axis_tdata  = S_DATA_W'({cmd.blk, cmd.ey, cmd.ex, cmd.sy, cmd.sx});
        s_axis_tuser  = cmd.op;
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        apply_cmd(cmd);
        burst_left--;
    endtask

    task automatic send_cast(input int sx, input int sy, input int ex, input int ey);
        ray_cmd_t cmd;
        cmd.op  = OP_CAST;
        cmd.sx  = coord_t'(sx);
        cmd.sy  = coord_t'(sy);
        cmd.ex  = coord_t'(ex);
        cmd.ey  = coord_t'(ey);
        cmd.blk = 1'($urandom_range(0, 1));
        send_cmd(cmd);
    endtask

    task automatic send_write(input int x, input int y, input bit blk);
        ray_cmd_t cmd;
        cmd.op  = OP_WRITE;
        cmd.sx  = coord_t'(x);
        cmd.sy  = coord_t'(y);
        cmd.ex  = coord_t'($urandom_range(0, GRID_SIDE - 1));
        cmd.ey  = coord_t'($urandom_range(0, GRID_SIDE - 1));
        cmd.blk = blk;
        send_cmd(cmd);
    endtask

    // every line shape in several directions, zero length and full length
    task automatic test_ray_shapes();
        send_cast(0, 0, 0, 0);
        send_cast(63, 63, 63, 63);
        send_cast(0, 0, 63, 63);
        send_cast(63, 0, 0, 63);
        send_cast(0, 10, 63, 20);
        send_cast(63, 40, 0, 33);
        send_cast(5, 0, 12, 63);
        send_cast(30, 63, 21, 0);
        send_cast(0, 5, 63, 5);
        send_cast(7, 63, 7, 0);
        send_cast(10, 10, 13, 12);
    endtask

    // blocking start, mid-line and end-tile blockers, map corners, clearing
    task automatic test_blockers();
        send_write(20, 20, 1'b1);
        send_cast(20, 20, 30, 25);
        send_write(40, 40, 1'b1);
        send_cast(30, 40, 50, 40);
        send_cast(30, 40, 40, 40);
        send_cast(40, 45, 40, 39);
        send_write(63, 63, 1'b1);
        send_cast(0, 0, 63, 63);
        send_write(40, 40, 1'b0);
        send_cast(30, 40, 50, 40);
        send_write(63, 63, 1'b0);
        send_write(20, 20, 1'b0);
    endtask

    // dense blocker writes and casts inside a moving window, plus noise
    task automatic test_random_mixed(input int n_items);
        int bx;
        int by;
        int pick;
        bx = 0;
        by = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 20 == 0) begin
                bx = $urandom_range(0, GRID_SIDE - 12);
                by = $urandom_range(0, GRID_SIDE - 12);
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_write(bx + $urandom_range(0, 11), by + $urandom_range(0, 11),
                           $urandom_range(0, 3) != 0);
            else if (pick < 45)
                send_write($urandom_range(0, GRID_SIDE - 1), $urandom_range(0, GRID_SIDE - 1),
                           1'($urandom_range(0, 1)));
            else if (pick < 85)
                send_cast(bx + $urandom_range(0, 11), by + $urandom_range(0, 11),
                          bx + $urandom_range(0, 11), by + $urandom_range(0, 11));
            else
                send_cast($urandom_range(0, GRID_SIDE - 1), $urandom_range(0, GRID_SIDE - 1),
                          $urandom_range(0, GRID_SIDE - 1), $urandom_range(0, GRID_SIDE - 1));
        end
    endtask

    // long output hold-off while casts keep coming, so the input stalls
    task automatic test_backpressure();
        int x0;
        int y0;
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++) begin
            x0 = $urandom_range(0, GRID_SIDE - 1);
            y0 = $urandom_range(0, GRID_SIDE - 1);
            send_cast(x0, y0, $urandom_range(0, GRID_SIDE - 1), $urandom_range(0, GRID_SIDE - 1));
        end
    endtask

    // receiver: changing stall pattern, with a long hold-off on request
    initial begin : rx_ready_gen
        int hold_left;
        int mode;
        int rx_cycle;
        hold_left = 0;
        mode = 0;
        rx_cycle = 0;
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (rx_cycle % 50 == 0)
                mode = $urandom_range(0, 3);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                case (mode)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = 1'($urandom_range(0, 1));
                    2: m_axis_tready = $urandom_range(0, 7) != 0;
                    default: m_axis_tready = (rx_cycle % 4) == 0;
                endcase
            end
        end
    end

    // compare each result transfer with the oldest predicted tile
    always @(posedge aclk) begin
        tile_t exp_t;
        tile_t act_t;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            act_t.x    = m_axis_tdata[COORD_W-1:0];
            act_t.y    = m_axis_tdata[2*COORD_W-1:COORD_W];
            act_t.hit  = m_axis_tuser;
            act_t.last = m_axis_tlast;
            n_tiles++;
            if (act_t.hit)
                n_hits++;
            if (pending_tiles.size() == 0) begin
                n_errors++;
                $display("%0t unexpected tile: actual x=%0d y=%0d hit=%0b last=%0b",
                         $time, act_t.x, act_t.y, act_t.hit, act_t.last);
            end else begin
                exp_t = pending_tiles.pop_front();
                if (act_t.x !== exp_t.x || act_t.y !== exp_t.y ||
                    act_t.hit !== exp_t.hit || act_t.last !== exp_t.last) begin
                    n_errors++;
                    $display("%0t tile mismatch: expected x=%0d y=%0d hit=%0b last=%0b, actual x=%0d y=%0d hit=%0b last=%0b",
                             $time, exp_t.x, exp_t.y, exp_t.hit, exp_t.last,
                             act_t.x, act_t.y, act_t.hit, act_t.last);
                end
            end
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // main sequence
    initial begin
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        test_ray_shapes();
        test_blockers();
        test_random_mixed(80);
        test_backpressure();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (pending_tiles.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d casts and %0d map writes, %0d tiles seen, %0d ended on a blocker",
                 n_casts, n_writes, n_tiles, n_hits);
        $display("line shapes, blocker cases, bursty input, output stalls and a long hold-off");
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/brw_pkg.sv
rtl/brw_step_unit.sv
rtl/brw_map.sv
rtl/bresenham_ray_walker.sv
bench/bresenham_ray_walker_tb.sv
